// ----- rtl/asg_pkg.sv -----
// shared types and constants of the audio silence gate
`timescale 1ns / 1ps

package asg_pkg;

    localparam int MAX_CHANNELS_DEF = 8;
    localparam int COUNT_BITS_DEF   = 24;
    localparam int MAX_CHANNELS_TOP = 16;

    localparam int SILENCE_LEVEL = 5;
    localparam int LEVEL_SCALE   = 65536;

    localparam int SAMPLE_W   = 32;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CHAN_CFG_W = 4;
    localparam int FRAME_CNT_W = $clog2(MAX_CHANNELS_TOP + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD  = 2'd0,
        REG_WIDTH_MODE = 2'd1,
        REG_CHANNELS   = 2'd2
    } t_cfg_reg;

    typedef enum logic [1:0] {
        MODE_16    = 2'd0,
        MODE_32    = 2'd1,
        MODE_OTHER = 2'd2
    } t_width_mode;

    localparam logic [CHAN_CFG_W-1:0] CHANNELS_RESET = 4'd2;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] threshold;
        t_width_mode           mode;
        logic [CHAN_CFG_W-1:0] channels;
    } t_cfg;

    // core asks the output buffer to take a finished frame
    typedef struct packed {
        logic                   load;
        logic [FRAME_CNT_W-1:0] count;
    } t_frame_req;

    // output buffer tells the core whether it can take a frame now
    typedef struct packed {
        logic empty;
        logic finishing;
    } t_emit_stat;

endpackage

// ----- rtl/asg_if.sv -----
// stream interfaces for input samples and gated results
`timescale 1ns / 1ps

interface asg_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [asg_pkg::SAMPLE_W-1:0] sample_value;
    logic                                packet_end;

    modport source (output valid, output sample_value, output packet_end, input ready);
    modport sink (input valid, input sample_value, input packet_end, output ready);
endinterface

interface asg_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [asg_pkg::SAMPLE_W-1:0] out_sample;
    logic                                run_last;

    modport source (output valid, output out_sample, output run_last, input ready);
    modport sink (input valid, input out_sample, input run_last, output ready);
endinterface

// ----- rtl/asg_core.sv -----
// input register, silence classifier, run counter and frame store
`timescale 1ns / 1ps

module asg_core #(
    parameter int MAX_CHANNELS = asg_pkg::MAX_CHANNELS_DEF,
    parameter int COUNT_BITS   = asg_pkg::COUNT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  asg_pkg::t_cfg                 i_cfg,
    asg_in_if.sink                        i_sample,
    input  asg_pkg::t_emit_stat           i_emit_stat,
    output asg_pkg::t_frame_req           o_frame_req,
    output logic [asg_pkg::SAMPLE_W-1:0]  o_frame [MAX_CHANNELS]
);

    localparam int THR_W  = (COUNT_BITS < asg_pkg::CFG_DATA_W) ? COUNT_BITS
                                                               : asg_pkg::CFG_DATA_W;
    localparam int CNT_W  = THR_W + 1;
    localparam int FILL_W = $clog2(MAX_CHANNELS + 1);
    localparam int IDX_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CH5_W  = asg_pkg::CHAN_CFG_W + 1;

    localparam logic signed [15:0] LIM16 = 16'(asg_pkg::SILENCE_LEVEL);
    localparam logic signed [31:0] LIM32 =
        32'(asg_pkg::SILENCE_LEVEL * asg_pkg::LEVEL_SCALE);

    logic                          r_in_valid;
    logic [asg_pkg::SAMPLE_W-1:0]  r_in_sample;
    logic                          r_in_pend;
    logic [CNT_W-1:0]              r_count;
    logic [CNT_W-1:0]              n_count;
    logic [FILL_W-1:0]             r_fill;
    logic [FILL_W-1:0]             n_fill;
    logic [asg_pkg::SAMPLE_W-1:0]  r_store [MAX_CHANNELS];

    logic [THR_W-1:0]  thr;
    logic              quiet;
    logic [CH5_W-1:0]  ch_raw;
    logic [FILL_W-1:0] ch;
    logic [FILL_W-1:0] fill_inc;
    logic              complete;
    logic              pass;
    logic              need_emit;
    logic              go;

    assign thr = i_cfg.threshold[THR_W-1:0];

    always_comb begin
        case (i_cfg.mode)
            asg_pkg::MODE_16: begin
                quiet = ($signed(r_in_sample[15:0]) > -LIM16)
                     && ($signed(r_in_sample[15:0]) < LIM16);
            end
            asg_pkg::MODE_32: begin
                quiet = ($signed(r_in_sample) > -LIM32) && ($signed(r_in_sample) < LIM32);
            end
            default: begin
                quiet = 1'b0;
            end
        endcase
    end

    // zero means one channel, anything above the frame size saturates
    always_comb begin
        ch_raw = {1'b0, i_cfg.channels};
        if (ch_raw == '0) begin
            ch_raw = CH5_W'(1);
        end
        if (ch_raw > CH5_W'(MAX_CHANNELS)) begin
            ch_raw = CH5_W'(MAX_CHANNELS);
        end
        ch = FILL_W'(ch_raw);
    end

    always_comb begin
        n_count = r_count;
        if (thr != '0) begin
            if (r_count > CNT_W'(thr)) begin
                if (!quiet) begin
                    n_count = '0;
                end
            end else if (r_count != '0) begin
                n_count = quiet ? r_count + CNT_W'(1) : '0;
            end else if (quiet) begin
                n_count = CNT_W'(1);
            end
        end
    end

    assign fill_inc  = r_fill + FILL_W'(1);
    assign complete  = (fill_inc >= ch) || r_in_pend;
    assign pass      = (thr == '0) || (n_count <= CNT_W'(thr));
    assign need_emit = complete && pass;
    assign go        = r_in_valid
                    && (!need_emit || i_emit_stat.empty || i_emit_stat.finishing);

    assign i_sample.ready = !r_in_valid || go;
    assign n_fill         = complete ? '0 : fill_inc;

    assign o_frame_req.load  = go && need_emit;
    assign o_frame_req.count = asg_pkg::FRAME_CNT_W'(fill_inc);

    // the current item goes straight into its slot of the outgoing frame
    always_comb begin
        for (int k = 0; k < MAX_CHANNELS; k++) begin
            o_frame[k] = (FILL_W'(k) == r_fill) ? r_in_sample : r_store[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_count    <= '0;
            r_fill     <= '0;
        end else begin
            if (i_sample.ready) begin
                r_in_valid <= i_sample.valid;
            end
            if (go) begin
                r_count <= n_count;
                r_fill  <= n_fill;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sample.valid && i_sample.ready) begin
            r_in_sample <= i_sample.sample_value;
            r_in_pend   <= i_sample.packet_end;
        end
        if (go) begin
            r_store[r_fill[IDX_W-1:0]] <= r_in_sample;
        end
    end

`ifndef NO_ASSERTIONS
    a_fill_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill < FILL_W'(MAX_CHANNELS))
        else $error("frame fill beyond frame size");
    a_fill_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (go && complete) |=> (r_fill == '0))
        else $error("frame fill not cleared at frame end");
    a_count_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (go && thr == '0) |=> $stable(r_count))
        else $error("run counter moved with gating off");
`endif

endmodule

// ----- rtl/asg_emit.sv -----
// output buffer that drains a passed frame one item per cycle while the result sink is ready
`timescale 1ns / 1ps

module asg_emit #(
    parameter int MAX_CHANNELS = asg_pkg::MAX_CHANNELS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  asg_pkg::t_frame_req           i_frame_req,
    input  logic [asg_pkg::SAMPLE_W-1:0]  i_frame [MAX_CHANNELS],
    output asg_pkg::t_emit_stat           o_emit_stat,
    asg_out_if.source                     o_result
);

    localparam int LEFT_W = $clog2(MAX_CHANNELS + 1);
    localparam int IDX_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    logic [asg_pkg::SAMPLE_W-1:0] r_buf [MAX_CHANNELS];
    logic [LEFT_W-1:0]            r_left;
    logic [IDX_W-1:0]             r_idx;
    logic                         take;

    assign take = o_result.valid && o_result.ready;

    assign o_result.valid      = (r_left != '0);
    assign o_result.out_sample = r_buf[r_idx];
    assign o_result.run_last   = (r_left == LEFT_W'(1));

    assign o_emit_stat.empty     = (r_left == '0);
    assign o_emit_stat.finishing = (r_left == LEFT_W'(1)) && o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_idx  <= '0;
        end else if (i_frame_req.load) begin
            r_left <= i_frame_req.count[LEFT_W-1:0];
            r_idx  <= '0;
        end else if (take) begin
            r_left <= r_left - LEFT_W'(1);
            r_idx  <= r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_frame_req.load) begin
            r_buf <= i_frame;
        end
    end

`ifndef NO_ASSERTIONS
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_frame_req.load |-> ((r_left == '0) || ((r_left == LEFT_W'(1)) && o_result.ready)))
        else $error("frame loaded over an undrained frame");
    a_load_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_frame_req.load |-> ((i_frame_req.count != '0)
                          && (i_frame_req.count <= asg_pkg::FRAME_CNT_W'(MAX_CHANNELS))))
        else $error("frame length out of range");
    a_index_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_left != '0) |-> ((32'(r_idx) + 32'(r_left)) <= 32'(MAX_CHANNELS)))
        else $error("drain index runs past the frame");
`endif

endmodule

// ----- rtl/audio_silence_gate.sv -----
// a passed frame loads the output buffer as its last item leaves the input register
// throughput: one item per cycle; an input item that ends a passed frame waits while
//   the output buffer holds more than one item, or one while the sink is not ready,
// so a short passed frame closed by packet end right behind a longer passed frame stalls
// reset: synchronous active low; clears counter, frame fill, output; sets config defaults
// top level of the audio silence gate with its configuration registers
`timescale 1ns / 1ps

module audio_silence_gate #(
    parameter int MAX_CHANNELS = asg_pkg::MAX_CHANNELS_DEF,
    parameter int COUNT_BITS   = asg_pkg::COUNT_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [asg_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [asg_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    asg_in_if.sink                            i_sample,
    asg_out_if.source                         o_result
);

    localparam int THR_W = (COUNT_BITS < asg_pkg::CFG_DATA_W) ? COUNT_BITS
                                                              : asg_pkg::CFG_DATA_W;

    asg_pkg::t_cfg        r_cfg;
    asg_pkg::t_frame_req  frame_req;
    asg_pkg::t_emit_stat  emit_stat;
    logic [asg_pkg::SAMPLE_W-1:0] frame [MAX_CHANNELS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold <= '0;
            r_cfg.mode      <= asg_pkg::MODE_16;
            r_cfg.channels  <= asg_pkg::CHANNELS_RESET;
        end else if (i_cfg_we) begin
            case (asg_pkg::t_cfg_reg'(i_cfg_index))
                asg_pkg::REG_THRESHOLD: begin
                    r_cfg.threshold <= asg_pkg::CFG_DATA_W'(i_cfg_data[THR_W-1:0]);
                end
                asg_pkg::REG_WIDTH_MODE: begin
                    r_cfg.mode <= asg_pkg::t_width_mode'(i_cfg_data[1:0]);
                end
                asg_pkg::REG_CHANNELS: begin
                    r_cfg.channels <= i_cfg_data[asg_pkg::CHAN_CFG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    asg_core #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .COUNT_BITS   (COUNT_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_sample    (i_sample),
        .i_emit_stat (emit_stat),
        .o_frame_req (frame_req),
        .o_frame     (frame)
    );

    asg_emit #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_frame_req (frame_req),
        .i_frame     (frame),
        .o_emit_stat (emit_stat),
        .o_result    (o_result)
    );

endmodule
